FILE: rtl/core/tar_header_check_deframer_defines.svh
// Assertion macros for the tar deframer checker.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef TAR_HEADER_CHECK_DEFRAMER_DEFINES_SVH
`define TAR_HEADER_CHECK_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define THCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define THCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/thcd_pkg.sv
// Shared types and constants of the tar header checker and deframer.
// No dependencies; used by the result interface, the top level and the checker.
package thcd_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_EOA    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_OCTAL = 2'd1,
    CAUSE_CSUM  = 2'd2,
    CAUSE_TYPE  = 2'd3
  } cause_t;

  typedef enum logic [1:0] {
    ETYPE_FILE    = 2'd0,
    ETYPE_DIR     = 2'd1,
    ETYPE_SYMLINK = 2'd2
  } etype_t;

  localparam int unsigned SIZE_W = 36;
  localparam int unsigned MODE_W = 9;
  localparam int unsigned POS_W  = 9;

  // Header byte offsets; HI bounds are exclusive.
  localparam logic [POS_W-1:0] MODE_LO  = 9'd100;
  localparam logic [POS_W-1:0] MODE_HI  = 9'd108;
  localparam logic [POS_W-1:0] SIZE_LO  = 9'd124;
  localparam logic [POS_W-1:0] SIZE_HI  = 9'd136;
  localparam logic [POS_W-1:0] CSUM_LO  = 9'd148;
  localparam logic [POS_W-1:0] CSUM_HI  = 9'd156;
  localparam logic [POS_W-1:0] TYPE_POS = 9'd156;
  localparam logic [POS_W-1:0] LAST_POS = 9'd511;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_SYM   = 8'h32;
  localparam logic [7:0] CH_DIR   = 8'h35;

endpackage

FILE: rtl/core/thcd_if.sv
// Valid/ready channel interfaces for the tar deframer byte input and result output.
// Depends on thcd_pkg for the result field types.
interface thcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface thcd_out_if;
  logic                            valid;
  logic                            ready;
  thcd_pkg::kind_t                 result_kind;
  thcd_pkg::cause_t                error_cause;
  thcd_pkg::etype_t                entry_type;
  logic [thcd_pkg::SIZE_W-1:0]     file_size;
  logic [thcd_pkg::MODE_W-1:0]     file_mode;
  logic [7:0]                      data_byte;
  logic                            last_data;

  modport source (output valid, output result_kind, output error_cause,
                  output entry_type, output file_size, output file_mode,
                  output data_byte, output last_data, input ready);
  modport sink   (input valid, input result_kind, input error_cause,
                  input entry_type, input file_size, input file_mode,
                  input data_byte, input last_data, output ready);
endinterface

FILE: rtl/core/tar_header_check_deframer.sv
// A result word appears in the output register the cycle after its byte is taken.
// Throughput: one byte per clock; the input is ready whenever the output register is
// empty or being taken, so the single result register sets the rate.
// Reset (rst_n low, synchronous): header phase at block offset zero, no result pending.
// After an error or end of archive all bytes are taken and dropped until reset.
module tar_header_check_deframer (
  input  logic            clk,
  input  logic            rst_n,
  thcd_in_if.sink         in_ch,
  thcd_out_if.source      out_ch
);
  import thcd_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_DATA, PH_PAD, PH_HALT} phase_t;
  typedef enum logic [1:0] {DC_DIGIT, DC_STOP, DC_BAD} dclass_t;

  typedef struct packed {
    kind_t              kind;
    cause_t             cause;
    etype_t             etype;
    logic [SIZE_W-1:0]  size;
    logic [MODE_W-1:0]  mode;
    logic [7:0]         data;
    logic               last;
  } res_t;

  function automatic dclass_t octal_class(input logic [7:0] b);
    dclass_t c;
    if (b == CH_NUL || b == CH_SPACE) c = DC_STOP;
    else if (b < CH_ZERO || b > CH_SEVEN) c = DC_BAD;
    else c = DC_DIGIT;
    return c;
  endfunction

  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              prev_zero_r, prev_zero_nxt;
  logic              all_zero_r, all_zero_nxt;
  logic [16:0]       sum_r, sum_nxt;
  logic [23:0]       csum_r, csum_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [2:0]        stopped_r, stopped_nxt;
  logic [1:0]        fault_r, fault_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [SIZE_W-1:0] data_left_r, data_left_nxt;
  logic [POS_W-1:0]  pad_left_r, pad_left_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_nxt;

  logic        in_ready;
  logic        accept;
  logic        emit;
  logic [7:0]  b;
  logic        in_csum, in_mode, in_size;
  dclass_t     cls;
  logic [7:0]  tchar;
  logic [16:0] sum_add;
  cause_t      cause;
  etype_t      etype;

  assign in_ready = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ready;
  assign b        = in_ch.in_byte;
  assign in_csum  = (pos_r >= CSUM_LO) && (pos_r < CSUM_HI);
  assign in_mode  = (pos_r >= MODE_LO) && (pos_r < MODE_HI);
  assign in_size  = (pos_r >= SIZE_LO) && (pos_r < SIZE_HI);
  assign cls      = octal_class(b);
  assign tchar    = (type_r != CH_NUL) ? type_r : CH_ZERO;
  // checksum bytes count as spaces
  assign sum_add  = sum_r + 17'(in_csum ? CH_SPACE : b);

  // Header verdict; fields are final by the last byte of the block.
  always_comb begin
    cause = CAUSE_NONE;
    etype = ETYPE_FILE;
    if (fault_r[0]) cause = CAUSE_OCTAL;
    else if (csum_r != {7'd0, sum_add}) cause = CAUSE_CSUM;
    else if (fault_r[1]) cause = CAUSE_OCTAL;
    else if (tchar == CH_ZERO) etype = ETYPE_FILE;
    else if (tchar == CH_DIR) etype = ETYPE_DIR;
    else if (tchar == CH_SYM) etype = ETYPE_SYMLINK;
    else cause = CAUSE_TYPE;
  end

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    prev_zero_nxt = prev_zero_r;
    all_zero_nxt  = all_zero_r;
    sum_nxt       = sum_r;
    csum_nxt      = csum_r;
    mode_nxt      = mode_r;
    size_nxt      = size_r;
    stopped_nxt   = stopped_r;
    fault_nxt     = fault_r;
    type_nxt      = type_r;
    data_left_nxt = data_left_r;
    pad_left_nxt  = pad_left_r;
    emit          = 1'b0;
    res_nxt       = '0;
    res_nxt.kind  = KIND_HEADER;
    res_nxt.cause = CAUSE_NONE;
    res_nxt.etype = ETYPE_FILE;

    if (accept) begin
      case (phase_r)
        PH_DATA: begin
          emit         = 1'b1;
          res_nxt.kind = KIND_DATA;
          res_nxt.data = b;
          res_nxt.last = (data_left_r == 36'd1);
          if (data_left_r != '0) data_left_nxt = data_left_r - 36'd1;
          if (data_left_r <= 36'd1) phase_nxt = (pad_left_r != '0) ? PH_PAD : PH_HEADER;
        end
        PH_PAD: begin
          if (pad_left_r != '0) pad_left_nxt = pad_left_r - 9'd1;
          if (pad_left_r <= 9'd1) phase_nxt = PH_HEADER;
        end
        PH_HEADER: begin
          all_zero_nxt = all_zero_r && (b == CH_NUL);
          sum_nxt      = sum_add;
          if (in_csum) begin
            if (!stopped_r[0]) begin
              case (cls)
                DC_STOP: stopped_nxt[0] = 1'b1;
                DC_BAD: begin
                  fault_nxt[0]   = 1'b1;
                  stopped_nxt[0] = 1'b1;
                end
                default: csum_nxt = {csum_r[20:0], b[2:0]};
              endcase
            end
          end else if (in_mode) begin
            if (!stopped_r[1]) begin
              case (cls)
                DC_STOP: stopped_nxt[1] = 1'b1;
                DC_BAD: begin
                  fault_nxt[1]   = 1'b1;
                  stopped_nxt[1] = 1'b1;
                end
                default: mode_nxt = {mode_r[MODE_W-4:0], b[2:0]};
              endcase
            end
          end else if (in_size) begin
            if (!stopped_r[2]) begin
              case (cls)
                DC_STOP: stopped_nxt[2] = 1'b1;
                DC_BAD: begin
                  fault_nxt[1]   = 1'b1;
                  stopped_nxt[2] = 1'b1;
                end
                default: size_nxt = {size_r[SIZE_W-4:0], b[2:0]};
              endcase
            end
          end else if (pos_r == TYPE_POS) begin
            type_nxt = b;
          end

          if (pos_r != LAST_POS) begin
            pos_nxt = pos_r + 9'd1;
          end else begin
            if (all_zero_nxt) begin
              if (prev_zero_r) begin
                phase_nxt    = PH_HALT;
                emit         = 1'b1;
                res_nxt.kind = KIND_EOA;
              end
              prev_zero_nxt = 1'b1;
            end else begin
              prev_zero_nxt = 1'b0;
              emit          = 1'b1;
              if (cause != CAUSE_NONE) begin
                res_nxt.kind  = KIND_ERROR;
                res_nxt.cause = cause;
                phase_nxt     = PH_HALT;
              end else begin
                res_nxt.kind  = KIND_HEADER;
                res_nxt.etype = etype;
                res_nxt.size  = size_r;
                res_nxt.mode  = mode_r;
                if (etype == ETYPE_FILE && size_r != '0) begin
                  data_left_nxt = size_r;
                  pad_left_nxt  = 9'd0 - size_r[POS_W-1:0];
                  phase_nxt     = PH_DATA;
                end
              end
            end
            // start the next block clean
            pos_nxt      = '0;
            all_zero_nxt = 1'b1;
            sum_nxt      = '0;
            csum_nxt     = '0;
            mode_nxt     = '0;
            size_nxt     = '0;
            stopped_nxt  = '0;
            fault_nxt    = '0;
            type_nxt     = '0;
          end
        end
        default: begin
          // halted: drop the byte
        end
      endcase
    end

    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (accept) out_valid_nxt = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= '0;
      prev_zero_r <= 1'b0;
      all_zero_r  <= 1'b1;
      sum_r       <= '0;
      csum_r      <= '0;
      mode_r      <= '0;
      size_r      <= '0;
      stopped_r   <= '0;
      fault_r     <= '0;
      type_r      <= '0;
      data_left_r <= '0;
      pad_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      prev_zero_r <= prev_zero_nxt;
      all_zero_r  <= all_zero_nxt;
      sum_r       <= sum_nxt;
      csum_r      <= csum_nxt;
      mode_r      <= mode_nxt;
      size_r      <= size_nxt;
      stopped_r   <= stopped_nxt;
      fault_r     <= fault_nxt;
      type_r      <= type_nxt;
      data_left_r <= data_left_nxt;
      pad_left_r  <= pad_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload needs no reset; load only with a new result
    if (accept && emit) res_r <= res_nxt;
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = res_r.kind;
  assign out_ch.error_cause = res_r.cause;
  assign out_ch.entry_type  = res_r.etype;
  assign out_ch.file_size   = res_r.size;
  assign out_ch.file_mode   = res_r.mode;
  assign out_ch.data_byte   = res_r.data;
  assign out_ch.last_data   = res_r.last;

endmodule

FILE: rtl/core/thcd_checker.sv
// Port-level checker for the tar deframer result channel, with its bind.
// Depends on thcd_pkg and tar_header_check_deframer_defines.svh.
`include "tar_header_check_deframer_defines.svh"

module thcd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input thcd_pkg::kind_t             result_kind,
  input thcd_pkg::cause_t            error_cause,
  input thcd_pkg::etype_t            entry_type,
  input logic [thcd_pkg::SIZE_W-1:0] file_size,
  input logic [thcd_pkg::MODE_W-1:0] file_mode,
  input logic [7:0]                  data_byte,
  input logic                        last_data
);
  import thcd_pkg::*;

  // a stalled word stays valid and keeps its kind, size, mode, data and last mark
  `THCD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(file_size) && $stable(file_mode) && $stable(data_byte) && $stable(last_data), "stalled result word changed")

  // only an error carries a cause
  `THCD_ASSERT_NOW(a_cause_only_error, out_valid && result_kind != KIND_ERROR, error_cause == CAUSE_NONE, "cause set on a non-error word")

  // the last-data mark belongs to data words, and no header reports an unknown type
  `THCD_ASSERT_NOW(a_last_is_data, out_valid && (last_data || result_kind == KIND_HEADER), (!last_data || result_kind == KIND_DATA) && (entry_type == ETYPE_FILE || entry_type == ETYPE_DIR || entry_type == ETYPE_SYMLINK), "bad last mark or entry type")

  // error and end of archive are terminal: nothing follows a taken one
  `THCD_ASSERT_NEXT(a_terminal, out_valid && out_ready && (result_kind == KIND_ERROR || result_kind == KIND_EOA), !out_valid, "result word after terminal word")

endmodule

bind tar_header_check_deframer thcd_checker u_thcd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_kind (out_ch.result_kind),
  .error_cause (out_ch.error_cause),
  .entry_type  (out_ch.entry_type),
  .file_size   (out_ch.file_size),
  .file_mode   (out_ch.file_mode),
  .data_byte   (out_ch.data_byte),
  .last_data   (out_ch.last_data)
);
